@@ sv/taylor_sine_cosine_core_macros.svh @@
// Assertion macros for the Taylor sine/cosine core.
// Included by the top level; depends on nothing else.
`ifndef TAYLOR_SINE_COSINE_CORE_MACROS_SVH
`define TAYLOR_SINE_COSINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsc assertion failed");
`define TSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsc assertion failed");
`else
`define TSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/tsc_pkg.sv @@
// Shared types and constants of the Taylor sine/cosine core.
// No dependencies.
`timescale 1ns / 1ps
package tsc_pkg;
    localparam int ANGLE_W  = 16;
    localparam int MAG_W    = 16;
    localparam int RES_W    = 32;
    localparam int TC_W     = 3;
    localparam int TERM_W   = 49;   // term magnitude, Q.32, capped at 2^48
    localparam int PROD_W   = TERM_W + MAG_W;
    localparam int ACC_W    = 54;   // signed Q.32 sums
    localparam int ACC_FRAC = 32;
    localparam logic [TC_W-1:0] TC_RESET = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_ACC,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        TU_IDLE,
        TU_MUL,
        TU_ALIGN,
        TU_DIV,
        TU_DONE
    } t_tu_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_tu_status;
endpackage

@@ sv/tsc_if.sv @@
// Handshake channels of the Taylor sine/cosine core: angle, result, config.
// Depends on tsc_pkg.
`timescale 1ns / 1ps
interface tsc_angle_if;
    logic                               valid;
    logic                               ready;
    logic signed [tsc_pkg::ANGLE_W-1:0] angle;
    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface tsc_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [tsc_pkg::RES_W-1:0] sine_value;
    logic signed [tsc_pkg::RES_W-1:0] cosine_value;
    logic                             overflow;
    modport source (output valid, output sine_value, output cosine_value,
                    output overflow, input ready);
    modport sink   (input valid, input sine_value, input cosine_value,
                    input overflow, output ready);
endinterface

interface tsc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tsc_pkg::TC_W-1:0]    term_count;
    modport source (output valid, output term_count, input ready);
    modport sink   (input valid, input term_count, output ready);
endinterface

@@ sv/tsc_term_unit.sv @@
// Bit-serial term step: floor(term * mag / (div << AFB)).
// Shift-add multiply, one multiplier bit a cycle, then restoring division,
// one quotient bit a cycle. Depends on tsc_pkg.
`timescale 1ns / 1ps
module tsc_term_unit #(
    parameter int P_W = 4,
    parameter int AFB = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [tsc_pkg::TERM_W-1:0]          i_term,
    input  logic [tsc_pkg::MAG_W-1:0]           i_mag,
    input  logic [P_W-1:0]                      i_div,
    output tsc_pkg::t_tu_status                 o_status,
    output logic [tsc_pkg::PROD_W-AFB-1:0]      o_quot
);
    import tsc_pkg::*;

    localparam int DIV_W = PROD_W - AFB;
    localparam int CNT_W = $clog2(DIV_W + 1);

    t_tu_state           r_phase, n_phase;
    logic [PROD_W-1:0]   r_mcand;
    logic [PROD_W-1:0]   r_acc;
    logic [MAG_W-1:0]    r_mplier;
    logic [DIV_W-1:0]    r_quo;
    logic [P_W-1:0]      r_rem;
    logic [P_W-1:0]      r_div;
    logic [CNT_W-1:0]    r_cnt;
    logic [P_W:0]        trial;
    logic [P_W:0]        diff;
    logic                ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            TU_IDLE:  if (i_start) n_phase = TU_MUL;
            TU_MUL:   if (r_cnt == CNT_W'(MAG_W - 1)) n_phase = TU_ALIGN;
            TU_ALIGN: n_phase = TU_DIV;
            TU_DIV:   if (r_cnt == CNT_W'(DIV_W - 1)) n_phase = TU_DONE;
            TU_DONE:  n_phase = TU_IDLE;
            default:  n_phase = TU_IDLE;
        endcase
    end

    always_comb begin
        o_status.busy = (r_phase != TU_IDLE);
        o_status.done = (r_phase == TU_DONE);
        o_quot        = r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= TU_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            TU_IDLE: begin
                if (i_start) begin
                    r_mcand  <= PROD_W'(i_term);
                    r_mplier <= i_mag;
                    r_acc    <= '0;
                    r_div    <= i_div;
                    r_cnt    <= '0;
                end
            end
            TU_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
            end
            TU_ALIGN: begin
                r_quo <= r_acc[PROD_W-1:AFB];
                r_rem <= '0;
                r_cnt <= '0;
            end
            TU_DIV: begin
                r_rem <= ge ? diff[P_W-1:0] : trial[P_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end
endmodule

@@ sv/taylor_sine_cosine_core.sv @@
// Taylor sine/cosine core: takes a signed Q3.12 angle and returns truncated
// series sine and cosine in signed Q15.16, saturated, with an overflow flag.
// Terms are built one power at a time on a bit-serial multiply/divide unit:
// each power runs a shift-add multiply, an alignment step and a restoring
// division, then is accumulated; with n the clamped term count, 2n - 1 powers run.
// A new angle is accepted as soon as the previous result is placed in the
// output register. Depends on tsc_pkg, tsc_if, tsc_term_unit and the macros.
`timescale 1ns / 1ps
`include "taylor_sine_cosine_core_macros.svh"
module taylor_sine_cosine_core #(
    parameter int MAX_TERMS       = 6,
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsc_angle_if.sink   i_angle,
    tsc_cfg_if.sink     i_cfg,
    tsc_result_if.source o_result
);
    import tsc_pkg::*;

    localparam int P_W   = $clog2(2 * MAX_TERMS);
    localparam int DIV_W = PROD_W - ANGLE_FRAC_BITS;
    localparam int SH_W  = ACC_W - 16;
    localparam logic [DIV_W-1:0] TERM_CAP = DIV_W'(1) << 48;

    t_state               r_state, n_state;
    logic [TC_W-1:0]      r_term_count;
    logic                 r_neg;
    logic [MAG_W-1:0]     r_mag;
    logic [TERM_W-1:0]    r_m;
    logic [P_W-1:0]       r_p;
    logic [P_W-1:0]       r_last;
    logic signed [ACC_W-1:0] r_s_acc;
    logic signed [ACC_W-1:0] r_c_acc;
    logic                 r_sat;
    logic                 r_out_valid;
    logic signed [RES_W-1:0] r_sine;
    logic signed [RES_W-1:0] r_cosine;
    logic                 r_overflow;

    t_tu_status           tu_status;
    logic [DIV_W-1:0]     tu_quot;
    logic                 tu_start;
    logic                 in_take;
    logic                 out_load;
    logic [P_W-1:0]       n_clamped;
    logic                 cap_hit;
    logic [TERM_W-1:0]    term_capped;
    logic signed [ACC_W-1:0] term_val;
    logic                 p_bit1;
    logic [MAG_W-1:0]     in_mag;
    logic [RES_W-1:0]     sine_sat;
    logic [RES_W-1:0]     cosine_sat;
    logic                 sine_ovf;
    logic                 cosine_ovf;

    function automatic logic [RES_W:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        logic signed [SH_W-1:0]  sh;
        logic [RES_W:0]          res;
        r  = v + ACC_W'(32768);
        sh = SH_W'(r >>> 16);
        if (sh > SH_W'(64'sh7FFF_FFFF)) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (sh < -SH_W'(64'sh8000_0000)) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, sh[RES_W-1:0]};
        end
        return res;
    endfunction

    tsc_term_unit #(
        .P_W (P_W),
        .AFB (ANGLE_FRAC_BITS)
    ) u_term (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (tu_start),
        .i_term   (r_m),
        .i_mag    (r_mag),
        .i_div    (r_p),
        .o_status (tu_status),
        .o_quot   (tu_quot)
    );

    // Term count of zero acts as one; counts above MAX_TERMS act as MAX_TERMS.
    always_comb begin
        if (r_term_count == '0) begin
            n_clamped = P_W'(1);
        end else if (32'(r_term_count) > MAX_TERMS) begin
            n_clamped = P_W'(MAX_TERMS);
        end else begin
            n_clamped = P_W'(r_term_count);
        end
    end

    assign in_mag      = i_angle.angle[ANGLE_W-1] ? MAG_W'(-i_angle.angle)
                                                  : MAG_W'(i_angle.angle);
    assign cap_hit     = tu_quot > TERM_CAP;
    assign term_capped = cap_hit ? TERM_W'(TERM_CAP) : tu_quot[TERM_W-1:0];
    assign term_val    = ACC_W'(term_capped);
    assign p_bit1      = ((32'(r_p) >> 1) & 32'd1) != 32'd0;
    assign {sine_ovf, sine_sat}     = round_sat(r_s_acc);
    assign {cosine_ovf, cosine_sat} = round_sat(r_c_acc);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_angle.valid) n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (tu_status.done) n_state = S_ACC;
            S_ACC:   n_state = (r_p == r_last) ? S_FIN : S_START;
            S_FIN:   if (!r_out_valid || o_result.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_angle.ready = (r_state == S_IDLE);
        tu_start      = (r_state == S_START);
        out_load      = (r_state == S_FIN) && (!r_out_valid || o_result.ready);
        in_take       = i_angle.valid && (r_state == S_IDLE);
        i_cfg.ready   = 1'b1;
        o_result.valid        = r_out_valid;
        o_result.sine_value   = r_sine;
        o_result.cosine_value = r_cosine;
        o_result.overflow     = r_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TC_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_term_count <= i_cfg.term_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_neg   <= i_angle.angle[ANGLE_W-1];
            r_mag   <= in_mag;
            r_m     <= TERM_W'(1) << ACC_FRAC;
            r_p     <= P_W'(1);
            r_last  <= P_W'((n_clamped << 1) - 1'b1);
            r_s_acc <= '0;
            r_c_acc <= ACC_W'(1) <<< ACC_FRAC;
            r_sat   <= 1'b0;
        end
        if (r_state == S_ACC) begin
            r_m <= term_capped;
            if (cap_hit) begin
                r_sat <= 1'b1;
            end
            // Odd powers feed the sine, even powers the cosine.
            if (r_p[0]) begin
                r_s_acc <= (r_neg ^ p_bit1) ? r_s_acc - term_val : r_s_acc + term_val;
            end else begin
                r_c_acc <= p_bit1 ? r_c_acc - term_val : r_c_acc + term_val;
            end
            if (r_p != r_last) begin
                r_p <= r_p + 1'b1;
            end
        end
        if (out_load) begin
            r_sine     <= sine_sat;
            r_cosine   <= cosine_sat;
            r_overflow <= r_sat | sine_ovf | cosine_ovf;
        end
    end

    `TSC_ASSERT_IMPL(a_unit_idle_outside_item, i_clk, i_rst_n, r_state == S_IDLE, !tu_status.busy)
    `TSC_ASSERT_IMPL(a_power_within_last, i_clk, i_rst_n, r_state != S_IDLE, r_p <= r_last)
    `TSC_ASSERT_NEXT(a_start_launches_unit, i_clk, i_rst_n, tu_start, tu_status.busy)
endmodule
